### hdl/sm83alu_pkg.sv
// Shared types and constants of the SM83-style eight-bit ALU.
// Operation codes, CB group decode, flag bit positions, item and result records.
// No dependencies; compile first.
package sm83alu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned FLAG_W = 4;

    // Flag bit positions inside a flag nibble
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [DATA_W-1:0] DAA_LOW_ADJ    = 8'h06;
    localparam logic [DATA_W-1:0] DAA_HIGH_ADJ   = 8'h60;
    localparam logic [DATA_W-1:0] DAA_HIGH_LIMIT = 8'h99;
    localparam logic [3:0]        DAA_DIGIT_MAX  = 4'h9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SBC  = 5'd3,
        OP_AND  = 5'd4,
        OP_XOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_CP   = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_RLCA = 5'd10,
        OP_RRCA = 5'd11,
        OP_RLA  = 5'd12,
        OP_RRA  = 5'd13,
        OP_DAA  = 5'd14,
        OP_CPL  = 5'd15,
        OP_SCF  = 5'd16,
        OP_CCF  = 5'd17,
        OP_CB   = 5'd18
    } alu_op_t;

    // CB byte bits 7:6
    typedef enum logic [1:0] {
        CB_GRP_SHIFT = 2'd0,
        CB_GRP_BIT   = 2'd1,
        CB_GRP_RES   = 2'd2,
        CB_GRP_SET   = 2'd3
    } cb_group_t;

    // CB byte bits 5:3 inside the shift group
    typedef enum logic [2:0] {
        CB_RLC  = 3'd0,
        CB_RRC  = 3'd1,
        CB_RL   = 3'd2,
        CB_RR   = 3'd3,
        CB_SLA  = 3'd4,
        CB_SRA  = 3'd5,
        CB_SWAP = 3'd6,
        CB_SRL  = 3'd7
    } cb_shift_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [FLAG_W-1:0] flags_in;
    } alu_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
        logic              write_result;
    } alu_res_t;

    function automatic logic [FLAG_W-1:0] mk_flags(logic z, logic n, logic h, logic c);
        logic [FLAG_W-1:0] f;
        f         = '0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

endpackage

### hdl/sm83alu_if.sv
// Valid/ready channel interfaces of the SM83-style ALU: operation in, result out.
// Depends on sm83alu_pkg for field widths.
interface sm83alu_in_if;
    import sm83alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [FLAG_W-1:0] flags_in;

    modport source (output valid, output op, output operand_a, output operand_b,
                    output flags_in, input ready);
    modport sink   (input valid, input op, input operand_a, input operand_b,
                    input flags_in, output ready);
endinterface

interface sm83alu_out_if;
    import sm83alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
    logic              write_result;

    modport source (output valid, output result, output flags_out, output write_result,
                    input ready);
    modport sink   (input valid, input result, input flags_out, input write_result,
                    output ready);
endinterface

### hdl/sm83alu_cb.sv
// CB-prefixed group: rotates, shifts, SWAP, BIT, RES and SET, decoded from the raw CB byte.
// Purely combinational; depends on sm83alu_pkg.
module sm83alu_cb (
    input  logic [sm83alu_pkg::DATA_W-1:0] value,
    input  logic [sm83alu_pkg::DATA_W-1:0] code,
    input  logic [sm83alu_pkg::FLAG_W-1:0] flags_in,
    output sm83alu_pkg::alu_res_t          res
);
    import sm83alu_pkg::*;

    logic [2:0]        bit_sel;
    logic [DATA_W-1:0] bit_mask;
    logic [DATA_W-1:0] shift_val;
    logic              shift_c;
    logic              cin;

    assign bit_sel  = code[5:3];
    assign bit_mask = {{(DATA_W-1){1'b0}}, 1'b1} << bit_sel;
    assign cin      = flags_in[FLAG_C];

    always_comb
    begin
        case (code[5:3])
            CB_RLC:  begin shift_val = {value[6:0], value[7]};      shift_c = value[7]; end
            CB_RRC:  begin shift_val = {value[0], value[7:1]};      shift_c = value[0]; end
            CB_RL:   begin shift_val = {value[6:0], cin};           shift_c = value[7]; end
            CB_RR:   begin shift_val = {cin, value[7:1]};           shift_c = value[0]; end
            CB_SLA:  begin shift_val = {value[6:0], 1'b0};          shift_c = value[7]; end
            CB_SRA:  begin shift_val = {value[7], value[7:1]};      shift_c = value[0]; end
            CB_SWAP: begin shift_val = {value[3:0], value[7:4]};    shift_c = 1'b0;     end
            CB_SRL:  begin shift_val = {1'b0, value[7:1]};          shift_c = value[0]; end
            default: begin shift_val = value;                       shift_c = 1'b0;     end
        endcase
    end

    always_comb
    begin
        res.result       = value;
        res.flags_out    = flags_in;
        res.write_result = 1'b1;
        case (code[7:6])
            CB_GRP_SHIFT:
            begin
                res.result    = shift_val;
                res.flags_out = mk_flags(shift_val == '0, 1'b0, 1'b0, shift_c);
            end
            CB_GRP_BIT:
            begin
                // test only: target untouched, carry kept
                res.write_result = 1'b0;
                res.flags_out    = mk_flags(!value[bit_sel], 1'b0, 1'b1, cin);
            end
            CB_GRP_RES: res.result = value & ~bit_mask;
            CB_GRP_SET: res.result = value | bit_mask;
            default:    res.result = value;
        endcase
    end

endmodule

### hdl/sm83alu_exec.sv
// Single-pass execute logic of the SM83-style ALU: arithmetic, logic, rotates, DAA, flag ops.
// Purely combinational; depends on sm83alu_pkg and sm83alu_cb.
module sm83alu_exec (
    input  sm83alu_pkg::alu_item_t item,
    output sm83alu_pkg::alu_res_t  res
);
    import sm83alu_pkg::*;

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [FLAG_W-1:0] fl;
    logic              cin;
    logic              carry_use;
    logic [DATA_W:0]   add_sum;
    logic [4:0]        add_half;
    logic [DATA_W:0]   sub_diff;
    logic [4:0]        sub_half;
    logic [DATA_W-1:0] inc_val;
    logic [DATA_W-1:0] dec_val;
    logic              daa_sub;
    logic              daa_lo;
    logic              daa_hi;
    logic [DATA_W-1:0] daa_adj;
    logic [DATA_W-1:0] daa_val;
    alu_res_t          cb_res;

    assign a   = item.operand_a;
    assign b   = item.operand_b;
    assign fl  = item.flags_in;
    assign cin = fl[FLAG_C];

    assign carry_use = ((item.op == OP_ADC) || (item.op == OP_SBC)) ? cin : 1'b0;

    assign add_sum  = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, carry_use};
    assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, carry_use};
    // bit 8 / bit 4 of the difference is the borrow
    assign sub_diff = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, carry_use};
    assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, carry_use};

    assign inc_val = a + 8'd1;
    assign dec_val = a - 8'd1;

    // both decimal tests look at the accumulator before adjustment
    assign daa_sub = fl[FLAG_N];
    assign daa_lo  = fl[FLAG_H] || (!daa_sub && (a[3:0] > DAA_DIGIT_MAX));
    assign daa_hi  = cin || (!daa_sub && (a > DAA_HIGH_LIMIT));
    assign daa_adj = (daa_lo ? DAA_LOW_ADJ : '0) | (daa_hi ? DAA_HIGH_ADJ : '0);
    assign daa_val = daa_sub ? (a - daa_adj) : (a + daa_adj);

    sm83alu_cb u_cb (
        .value    (a),
        .code     (b),
        .flags_in (fl),
        .res      (cb_res)
    );

    always_comb
    begin
        res.result       = a;
        res.flags_out    = fl;
        res.write_result = 1'b1;
        case (item.op)
            OP_ADD, OP_ADC:
            begin
                res.result    = add_sum[DATA_W-1:0];
                res.flags_out = mk_flags(add_sum[DATA_W-1:0] == '0, 1'b0,
                                         add_half[4], add_sum[DATA_W]);
            end
            OP_SUB, OP_SBC:
            begin
                res.result    = sub_diff[DATA_W-1:0];
                res.flags_out = mk_flags(sub_diff[DATA_W-1:0] == '0, 1'b1,
                                         sub_half[4], sub_diff[DATA_W]);
            end
            OP_CP:
            begin
                res.write_result = 1'b0;
                res.flags_out    = mk_flags(sub_diff[DATA_W-1:0] == '0, 1'b1,
                                            sub_half[4], sub_diff[DATA_W]);
            end
            OP_AND:
            begin
                res.result    = a & b;
                res.flags_out = mk_flags((a & b) == '0, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR:
            begin
                res.result    = a ^ b;
                res.flags_out = mk_flags((a ^ b) == '0, 1'b0, 1'b0, 1'b0);
            end
            OP_OR:
            begin
                res.result    = a | b;
                res.flags_out = mk_flags((a | b) == '0, 1'b0, 1'b0, 1'b0);
            end
            OP_INC:
            begin
                res.result    = inc_val;
                res.flags_out = mk_flags(inc_val == '0, 1'b0, inc_val[3:0] == 4'h0, cin);
            end
            OP_DEC:
            begin
                res.result    = dec_val;
                res.flags_out = mk_flags(dec_val == '0, 1'b1, dec_val[3:0] == 4'hF, cin);
            end
            OP_RLCA:
            begin
                res.result    = {a[6:0], a[7]};
                res.flags_out = mk_flags(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRCA:
            begin
                res.result    = {a[0], a[7:1]};
                res.flags_out = mk_flags(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_RLA:
            begin
                res.result    = {a[6:0], cin};
                res.flags_out = mk_flags(1'b0, 1'b0, 1'b0, a[7]);
            end
            OP_RRA:
            begin
                res.result    = {cin, a[7:1]};
                res.flags_out = mk_flags(1'b0, 1'b0, 1'b0, a[0]);
            end
            OP_DAA:
            begin
                res.result    = daa_val;
                res.flags_out = mk_flags(daa_val == '0, daa_sub, 1'b0, daa_hi);
            end
            OP_CPL:
            begin
                res.result    = ~a;
                res.flags_out = mk_flags(fl[FLAG_Z], 1'b1, 1'b1, cin);
            end
            OP_SCF:
            begin
                res.write_result = 1'b0;
                res.flags_out    = mk_flags(fl[FLAG_Z], 1'b0, 1'b0, 1'b1);
            end
            OP_CCF:
            begin
                res.write_result = 1'b0;
                res.flags_out    = mk_flags(fl[FLAG_Z], 1'b0, 1'b0, !cin);
            end
            OP_CB:   res = cb_res;
            // unassigned codes: no operation, nothing written
            default: res.write_result = 1'b0;
        endcase
    end

endmodule

### hdl/sm83_eight_bit_alu_core.sv
// Top level of the SM83-style eight-bit ALU with the CB-prefixed group.
// Depends on sm83alu_pkg, the channel interfaces, sm83alu_exec and sm83alu_cb.
//
// Each transfer on req carries an operation code, two operand bytes and the current Z/N/H/C
// flags; exactly one transfer on rsp follows with the computed byte, the new flags and a
// write-back strobe (low for CP, BIT, SCF, CCF and unassigned codes, where the byte returns
// operand_a unchanged). The block keeps no architectural state: flags travel with each item,
// so consecutive items are independent. The datapath is an input register, one pass of
// combinational execute logic and a result register. Throughput is one item per clock while
// rsp is not stalled; an item is registered in the input stage, then in the result register,
// which drives rsp.valid. req.ready stays high as long as the input stage is empty or the
// result register is empty or being drained, so a stalled consumer holds at most two items
// in flight before req.ready drops.
module sm83_eight_bit_alu_core (
    input  logic                clk,
    input  logic                rst_n,
    sm83alu_in_if.sink          req,
    sm83alu_out_if.source       rsp
);
    import sm83alu_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    alu_item_t in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    alu_res_t  out_res_reg;
    alu_res_t  exec_res;
    logic      out_free;
    logic      in_move;
    logic      in_xfer;

    // Result register can take a new value when empty or when its value transfers now
    assign out_free = !out_valid_reg || rsp.ready;
    // Advance the input stage into the result register
    assign in_move  = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign in_xfer   = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the input loads on a req transfer, the result on an advance; both hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.op        <= req.op;
            in_item_reg.operand_a <= req.operand_a;
            in_item_reg.operand_b <= req.operand_b;
            in_item_reg.flags_in  <= req.flags_in;
        end
        if (in_move)
        begin
            out_res_reg <= exec_res;
        end
    end

    sm83alu_exec u_exec (
        .item (in_item_reg),
        .res  (exec_res)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.result       = out_res_reg.result;
    assign rsp.flags_out    = out_res_reg.flags_out;
    assign rsp.write_result = out_res_reg.write_result;

    // An accepted item always lands in the input stage
    a_xfer_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    // An item leaving the input stage shows up as a valid result
    a_move_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_move |=> rsp.valid)
        else $error("advanced item lost before result register");

    // Both stages full and output stalled: no new item may enter
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input accepted while pipeline full");

    // A stalled input stage keeps its item
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input stage changed while stalled");

endmodule

### tb/sv/sm83_eight_bit_alu_core_chk.sv
`timescale 1ns / 100ps
// Scoreboard for the SM83-style eight-bit ALU: watches req and rsp, predicts each result.
// Depends on sm83alu_pkg and the channel interfaces in sm83alu_if.sv.
module sm83_eight_bit_alu_core_chk (
    input  logic        clk,
    input  logic        rst_n,
    sm83alu_in_if       req,
    sm83alu_out_if      rsp,
    output int unsigned err_count,
    output int unsigned open_count
);
    import sm83alu_pkg::*;

    typedef struct {
        alu_item_t item;
        alu_res_t  res;
    } alu_due_t;

    alu_due_t    results_due[$];
    int unsigned errors;

    // Flags are built as {Z, N, H, C}, matching bits 3..0 of the nibble.
    function automatic alu_res_t compute_alu(alu_item_t it);
        alu_res_t   r;
        logic [7:0] a, b, adj;
        logic [8:0] wide;
        logic [4:0] nib;
        logic       cin, cy, sub_mode;
        logic [2:0] sel;

        a   = it.operand_a;
        b   = it.operand_b;
        cin = it.flags_in[FLAG_C];
        sel = b[5:3];
        r.result       = a;
        r.flags_out    = it.flags_in;
        r.write_result = 1'b1;

        case (it.op)
            OP_ADD, OP_ADC: begin
                cy   = (it.op == OP_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + {8'h00, cy};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
                r.result    = wide[7:0];
                r.flags_out = {wide[7:0] == 8'h00, 1'b0, nib[4], wide[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                cy   = (it.op == OP_SBC) ? cin : 1'b0;
                wide = {1'b0, a} - {1'b0, b} - {8'h00, cy};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
                r.flags_out = {wide[7:0] == 8'h00, 1'b1, nib[4], wide[8]};
                if (it.op == OP_CP)
                    r.write_result = 1'b0;
                else
                    r.result = wide[7:0];
            end
            OP_AND: begin
                r.result    = a & b;
                r.flags_out = {r.result == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                r.result    = a ^ b;
                r.flags_out = {r.result == 8'h00, 3'b000};
            end
            OP_OR: begin
                r.result    = a | b;
                r.flags_out = {r.result == 8'h00, 3'b000};
            end
            OP_INC: begin
                r.result    = a + 8'h01;
                r.flags_out = {r.result == 8'h00, 1'b0, r.result[3:0] == 4'h0, cin};
            end
            OP_DEC: begin
                r.result    = a - 8'h01;
                r.flags_out = {r.result == 8'h00, 1'b1, r.result[3:0] == 4'hF, cin};
            end
            OP_RLCA: begin
                r.result    = {a[6:0], a[7]};
                r.flags_out = {3'b000, a[7]};
            end
            OP_RRCA: begin
                r.result    = {a[0], a[7:1]};
                r.flags_out = {3'b000, a[0]};
            end
            OP_RLA: begin
                r.result    = {a[6:0], cin};
                r.flags_out = {3'b000, a[7]};
            end
            OP_RRA: begin
                r.result    = {cin, a[7:1]};
                r.flags_out = {3'b000, a[0]};
            end
            OP_DAA: begin
                sub_mode = it.flags_in[FLAG_N];
                adj      = 8'h00;
                cy       = cin;
                if (it.flags_in[FLAG_H] || (!sub_mode && a[3:0] > 4'h9))
                    adj = 8'h06;
                // both digit tests look at the accumulator before adjustment
                if (cin || (!sub_mode && a > 8'h99))
                begin
                    adj = adj | 8'h60;
                    cy  = 1'b1;
                end
                r.result    = sub_mode ? (a - adj) : (a + adj);
                r.flags_out = {r.result == 8'h00, sub_mode, 1'b0, cy};
            end
            OP_CPL: begin
                r.result    = ~a;
                r.flags_out = {it.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF: begin
                r.write_result = 1'b0;
                r.flags_out    = {it.flags_in[FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            OP_CCF: begin
                r.write_result = 1'b0;
                r.flags_out    = {it.flags_in[FLAG_Z], 1'b0, 1'b0, ~cin};
            end
            OP_CB: begin
                case (cb_group_t'(b[7:6]))
                    CB_GRP_SHIFT: begin
                        case (cb_shift_t'(sel))
                            CB_RLC:  begin r.result = {a[6:0], a[7]};  cy = a[7]; end
                            CB_RRC:  begin r.result = {a[0], a[7:1]};  cy = a[0]; end
                            CB_RL:   begin r.result = {a[6:0], cin};   cy = a[7]; end
                            CB_RR:   begin r.result = {cin, a[7:1]};   cy = a[0]; end
                            CB_SLA:  begin r.result = {a[6:0], 1'b0};  cy = a[7]; end
                            CB_SRA:  begin r.result = {a[7], a[7:1]};  cy = a[0]; end
                            CB_SWAP: begin r.result = {a[3:0], a[7:4]}; cy = 1'b0; end
                            default: begin r.result = {1'b0, a[7:1]};  cy = a[0]; end
                        endcase
                        r.flags_out = {r.result == 8'h00, 1'b0, 1'b0, cy};
                    end
                    CB_GRP_BIT: begin
                        r.write_result = 1'b0;
                        r.flags_out    = {~a[sel], 1'b0, 1'b1, cin};
                    end
                    CB_GRP_RES: r.result = a & ~(8'h01 << sel);
                    default:    r.result = a | (8'h01 << sel);
                endcase
            end
            default: r.write_result = 1'b0;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        alu_item_t seen;
        alu_res_t  got;
        alu_due_t  want;

        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                seen = {req.op, req.operand_a, req.operand_b, req.flags_in};
                results_due.push_back('{seen, compute_alu(seen)});
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.result, rsp.flags_out, rsp.write_result};
                if (results_due.size() == 0)
                begin
                    $error("unexpected result transfer: result %h flags_out %h write_result %b",
                           got.result, got.flags_out, got.write_result);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.result !== want.res.result)
                    begin
                        $error("op %0d a %h b %h f %h: result expected %h, got %h",
                               want.item.op, want.item.operand_a, want.item.operand_b,
                               want.item.flags_in, want.res.result, got.result);
                        errors++;
                    end
                    if (got.flags_out !== want.res.flags_out)
                    begin
                        $error("op %0d a %h b %h f %h: flags_out expected %h, got %h",
                               want.item.op, want.item.operand_a, want.item.operand_b,
                               want.item.flags_in, want.res.flags_out, got.flags_out);
                        errors++;
                    end
                    if (got.write_result !== want.res.write_result)
                    begin
                        $error("op %0d a %h b %h f %h: write_result expected %b, got %b",
                               want.item.op, want.item.operand_a, want.item.operand_b,
                               want.item.flags_in, want.res.write_result, got.write_result);
                        errors++;
                    end
                end
            end
        end
        err_count  <= errors;
        open_count <= results_due.size();
    end

endmodule

### tb/sv/sm83_eight_bit_alu_core_tb.sv
`timescale 1ns / 100ps
// Top of the SM83-style ALU testbench: clock, reset, stimulus, output back-pressure, verdict.
// Depends on sm83alu_pkg, sm83alu_if.sv, the core RTL and sm83_eight_bit_alu_core_chk.
module sm83_eight_bit_alu_core_tb;
    import sm83alu_pkg::*;

    // Codes past OP_CB are unassigned and must behave as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd19;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 5'd31;
    // CB register select field (bits 2:0); it names the target only.
    localparam logic [2:0] CB_REG_B = 3'd0;
    localparam logic [2:0] CB_REG_A = 3'd7;

    localparam int RANDOM_ITEMS = 825;
    localparam int HOLD_CYCLES  = 60;    // long output hold-off
    localparam int HOLD_EVERY   = 300;   // result transfers between hold-offs
    localparam int IDLE_LIMIT   = 1000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 4;     // settle time after the last result

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sm83alu_in_if  req_if ();
    sm83alu_out_if rsp_if ();

    int unsigned err_count;
    int unsigned open_count;
    int unsigned ops_sent;
    int unsigned cb_sent;
    int unsigned unused_sent;
    int unsigned results_taken;
    int unsigned idle_cycles;
    bit          no_gaps;    // when set, neither side adds random gaps

    sm83_eight_bit_alu_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    sm83_eight_bit_alu_core_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .err_count  (err_count),
        .open_count (open_count)
    );

    always #4 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;

        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // Operand byte: a quarter of the time pick a boundary value, else anything.
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[10] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F,
                                  8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};

        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 9)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] cb_byte(cb_group_t grp, logic [2:0] sel, logic [2:0] target);
        return {grp, sel, target};
    endfunction

    // Offer one operation, hold it until the transfer, then idle a random gap.
    // Valid stays high across back-to-back items, so it is never lowered and
    // raised within one time step.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [7:0] a,
                           input logic [7:0] b, input logic [3:0] fl);
        int gap;

        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        req_if.flags_in  <= fl;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        ops_sent++;
        if (op == OP_CB)
            cb_sent++;
        if (op > OP_CB)
            unused_sent++;
        gap = pause_len();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Reset: hold low once from the start, then release at a rising edge.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, plus a long hold-off every HOLD_EVERY
    // transfers while the sender keeps offering, so the pipe fills and
    // req.ready drops.
    initial
    begin : result_sink
        int stall_left;
        int next_hold;

        stall_left   = 0;
        next_hold    = HOLD_EVERY;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                results_taken++;
            if (results_taken == next_hold)
            begin
                next_hold    += HOLD_EVERY;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pause_len();
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, open_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [OP_W-1:0] op;
        int              pick;

        req_if.valid     <= 1'b0;
        req_if.op        <= OP_ADD;
        req_if.operand_a <= 8'h00;
        req_if.operand_b <= 8'h00;
        req_if.flags_in  <= 4'h0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed: one pass over every operation with boundary operands.
        send_op(OP_ADD,  8'hFF, 8'h01, 4'h0);   // wraps to zero: Z, H and C
        send_op(OP_ADC,  8'h0F, 8'h00, 4'h1);   // carry in crosses the low digit
        send_op(OP_SUB,  8'h00, 8'h01, 4'h0);   // full borrow
        send_op(OP_SBC,  8'h10, 8'h0F, 4'h1);   // borrow in lands on zero
        send_op(OP_AND,  8'hFF, 8'h00, 4'hF);
        send_op(OP_XOR,  8'h5A, 8'h5A, 4'h0);
        send_op(OP_OR,   8'hA5, 8'h5A, 4'hF);
        send_op(OP_CP,   8'h3C, 8'h3C, 4'h0);   // no write-back, A returned
        send_op(OP_INC,  8'hFF, 8'h00, 4'h1);   // carry passes through
        send_op(OP_DEC,  8'h10, 8'h00, 4'h0);
        send_op(OP_RLCA, 8'h80, 8'h00, 4'hE);
        send_op(OP_RRCA, 8'h01, 8'h00, 4'hE);
        send_op(OP_RLA,  8'h80, 8'h00, 4'h0);
        send_op(OP_RRA,  8'h01, 8'h00, 4'h1);
        send_op(OP_DAA,  8'h9A, 8'h00, 4'h0);   // both digits over range after an add
        send_op(OP_DAA,  8'h0F, 8'h00, 4'h6);   // after a subtract with half borrow
        send_op(OP_DAA,  8'h99, 8'h00, 4'h0);   // upper bound, no high adjust
        send_op(OP_CPL,  8'h00, 8'h00, 4'h9);
        send_op(OP_SCF,  8'h77, 8'h00, 4'hE);
        send_op(OP_CCF,  8'h77, 8'h00, 4'h1);
        send_op(OP_CB,   8'hF0, cb_byte(CB_GRP_SHIFT, CB_SWAP, CB_REG_A), 4'hF);
        send_op(OP_CB,   8'h00, cb_byte(CB_GRP_BIT, 3'd7, CB_REG_B), 4'h1);
        send_op(OP_CB,   8'hFF, cb_byte(CB_GRP_RES, 3'd0, CB_REG_A), 4'h5);
        send_op(OP_CB,   8'h00, cb_byte(CB_GRP_SET, 3'd7, CB_REG_B), 4'hA);
        send_op(OP_UNUSED_HI, 8'hFF, 8'hFF, 4'hF);

        // Random: mostly assigned operations, a fair share of CB bytes and a
        // few unassigned codes; flip gap-free stretches every hundred items.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else if (pick < 30)
                op = OP_CB;
            else
                op = OP_W'($urandom_range(OP_ADD, OP_CCF));
            send_op(op, pick_byte(), pick_byte(), 4'($urandom_range(0, 15)));
        end

        // Drain: drop valid, wait for every expected result, then let the
        // pipeline settle so a stray extra transfer would still be caught.
        req_if.valid <= 1'b0;
        no_gaps = 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d operations (%0d CB-prefixed, %0d unassigned codes), %0d results",
                 ops_sent, cb_sent, unused_sent, results_taken);
        $display("with random gaps on both sides and %0d-cycle output hold-offs", HOLD_CYCLES);
        if (err_count == 0 && open_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
